>>> rtl/wfs_pkg.sv
// Shared types and codes for the wire field serializer.
`default_nettype none

package wfs_pkg;

    // Field kinds carried on the input tuser
    localparam logic [3:0] KIND_I8          = 4'd0;
    localparam logic [3:0] KIND_I16         = 4'd1;
    localparam logic [3:0] KIND_I32         = 4'd2;
    localparam logic [3:0] KIND_I64         = 4'd3;
    localparam logic [3:0] KIND_SVARINT     = 4'd4;
    localparam logic [3:0] KIND_UVARINT     = 4'd5;
    localparam logic [3:0] KIND_BOOL        = 4'd6;
    localparam logic [3:0] KIND_ARRAYLEN    = 4'd7;
    localparam logic [3:0] KIND_BYTESLEN    = 4'd8;
    localparam logic [3:0] KIND_STRLEN      = 4'd9;
    localparam logic [3:0] KIND_NULLSTR     = 4'd10;
    localparam logic [3:0] KIND_NULLARR     = 4'd11;
    localparam logic [3:0] KIND_VARBYTESLEN = 4'd12;
    localparam logic [3:0] KIND_TAGGED      = 4'd13;
    localparam logic [3:0] KIND_RAW         = 4'd14;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLEXIBLE = 2'd0;
    localparam logic [1:0] CFG_MEASURE  = 2'd1;
    localparam logic [1:0] CFG_LIMIT    = 2'd2;

    localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // How the byte unit walks the loaded word
    typedef enum logic [1:0] {
        ENC_NONE,
        ENC_BE,
        ENC_VAR
    } t_enc;

    // Load word for the byte unit: big-endian values are left-aligned
    typedef struct packed {
        t_enc        enc;
        logic [3:0]  cnt;
        logic [63:0] val;
    } t_load;

    // One step of the byte unit
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_step;

endpackage

`default_nettype wire

>>> rtl/wfs_decode.sv
// Field decode: maps kind, value and header mode to a byte unit load word.
`default_nettype none

module wfs_decode (
    input  wire logic [3:0]    i_kind,
    input  wire logic [63:0]   i_value,
    input  wire logic          i_flexible,
    output wfs_pkg::t_load     o_load
);

    logic [63:0] v_plus1;
    logic [63:0] zz_value;
    logic        v_zero;

    assign v_plus1  = i_value + 64'd1;
    assign v_zero   = (i_value == 64'd0);
    // zigzag: (v << 1) ^ sign mask
    assign zz_value = {i_value[62:0], 1'b0} ^ {64{i_value[63]}};

    always_comb begin
        o_load.enc = wfs_pkg::ENC_NONE;
        o_load.cnt = 4'd0;
        o_load.val = 64'd0;
        unique case (i_kind)
            wfs_pkg::KIND_I8, wfs_pkg::KIND_RAW: begin
                o_load.enc = wfs_pkg::ENC_BE;
                o_load.cnt = 4'd1;
                o_load.val = {i_value[7:0], 56'd0};
            end
            wfs_pkg::KIND_I16: begin
                o_load.enc = wfs_pkg::ENC_BE;
                o_load.cnt = 4'd2;
                o_load.val = {i_value[15:0], 48'd0};
            end
            wfs_pkg::KIND_I32: begin
                o_load.enc = wfs_pkg::ENC_BE;
                o_load.cnt = 4'd4;
                o_load.val = {i_value[31:0], 32'd0};
            end
            wfs_pkg::KIND_I64: begin
                o_load.enc = wfs_pkg::ENC_BE;
                o_load.cnt = 4'd8;
                o_load.val = i_value;
            end
            wfs_pkg::KIND_SVARINT: begin
                o_load.enc = wfs_pkg::ENC_VAR;
                o_load.val = zz_value;
            end
            wfs_pkg::KIND_UVARINT: begin
                o_load.enc = wfs_pkg::ENC_VAR;
                o_load.val = i_value;
            end
            wfs_pkg::KIND_BOOL: begin
                o_load.enc = wfs_pkg::ENC_BE;
                o_load.cnt = 4'd1;
                o_load.val = {7'd0, ~v_zero, 56'd0};
            end
            wfs_pkg::KIND_ARRAYLEN: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                    o_load.val = v_plus1;
                end else begin
                    o_load.enc = wfs_pkg::ENC_BE;
                    o_load.cnt = 4'd4;
                    o_load.val = {i_value[31:0], 32'd0};
                end
            end
            wfs_pkg::KIND_BYTESLEN: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                    o_load.val = v_plus1;
                end else begin
                    // empty byte string goes out as the null header
                    o_load.enc = wfs_pkg::ENC_BE;
                    o_load.cnt = 4'd4;
                    o_load.val = {(v_zero ? 32'hFFFF_FFFF : i_value[31:0]), 32'd0};
                end
            end
            wfs_pkg::KIND_STRLEN: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                    o_load.val = v_plus1;
                end else begin
                    o_load.enc = wfs_pkg::ENC_BE;
                    o_load.cnt = 4'd2;
                    o_load.val = {i_value[15:0], 48'd0};
                end
            end
            wfs_pkg::KIND_NULLSTR: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                end else begin
                    o_load.enc = wfs_pkg::ENC_BE;
                    o_load.cnt = 4'd2;
                    o_load.val = {16'hFFFF, 48'd0};
                end
            end
            wfs_pkg::KIND_NULLARR: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                end else begin
                    o_load.enc = wfs_pkg::ENC_BE;
                    o_load.cnt = 4'd4;
                    o_load.val = {32'hFFFF_FFFF, 32'd0};
                end
            end
            wfs_pkg::KIND_VARBYTESLEN: begin
                // zero is written as -1, whose zigzag form is 1
                o_load.enc = wfs_pkg::ENC_VAR;
                o_load.val = v_zero ? 64'd1 : zz_value;
            end
            wfs_pkg::KIND_TAGGED: begin
                if (i_flexible) begin
                    o_load.enc = wfs_pkg::ENC_VAR;
                end
            end
            default: begin
                o_load.enc = wfs_pkg::ENC_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/wfs_byte_unit.sv
// Shared shift unit: peels one wire byte per step off the loaded word.
`default_nettype none

module wfs_byte_unit (
    input  wire logic          i_clk,
    input  wire logic          i_load,
    input  wire wfs_pkg::t_load i_load_word,
    input  wire logic          i_step,
    output wfs_pkg::t_step     o_step
);

    wfs_pkg::t_enc r_enc;
    logic [3:0]    r_cnt;
    logic [63:0]   r_word;
    logic          more;

    assign more = |r_word[63:7];

    // Current byte and end-of-field flag
    always_comb begin
        if (r_enc == wfs_pkg::ENC_BE) begin
            o_step.data = r_word[63:56];
            o_step.last = (r_cnt == 4'd1);
        end else begin
            o_step.data = {more, r_word[6:0]};
            o_step.last = ~more;
        end
    end

    // Load or shift by one byte / one 7-bit group
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_enc  <= i_load_word.enc;
            r_cnt  <= i_load_word.cnt;
            r_word <= i_load_word.val;
        end else if (i_step) begin
            if (r_enc == wfs_pkg::ENC_BE) begin
                r_word <= {r_word[55:0], 8'd0};
                r_cnt  <= r_cnt - 4'd1;
            end else begin
                r_word <= {7'd0, r_word[63:7]};
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/wire_field_serializer.sv
// Top level: wire field serializer with sequencer, offset counter and output register.
//
// Input stream: one field per transfer, s_axis_tuser = kind (0..14), tdata = 64-bit value.
// Output stream: one transfer per wire byte; tlast marks the final byte of a field.
//   tdata = data byte and its byte offset, tuser = byte_valid and overflow flags.
// Configuration: write enable, 2-bit register index, 32-bit data; header mode,
//   measure mode and buffer limit; write only while the block is idle.
// Timing: the accept cycle loads a 64-bit shift unit; after that the unit gives
//   one byte per cycle while the output register can take it (always in
//   measure mode); the input stays not ready until a field of n bytes (1..10)
//   is done. The rate is set by the single byte-wide shift unit. In measure mode
//   the unit walks the n bytes, then one result with the new running total follows.
// A field that yields no bytes gives no transfer in emit mode.
// Bytes at offsets at or past the limit go out with byte_valid low and overflow
//   high; the running offset saturates at all ones.
// Reset clears offset, sequencer, output valid and mode bits; limit goes to all ones.
// A stalled receiver holds the output register; in emit mode the unit waits with it.
`default_nettype none

module wire_field_serializer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [63:0] value
    input  wire logic [3:0]  s_axis_tuser,   // [3:0] req_type
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] data_byte, [39:8] byte_offset
    output logic [1:0]       m_axis_tuser,   // [0] byte_valid, [1] overflow
    output logic             m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_REPORT
    } t_state;

    t_state         r_state;
    logic           r_flexible;
    logic           r_measure;
    logic [31:0]    r_limit;
    logic [31:0]    r_offset;

    logic           r_o_valid;
    logic [7:0]     r_o_byte;
    logic [31:0]    r_o_offset;
    logic           r_o_byte_valid;
    logic           r_o_ovf;
    logic           r_o_last;

    wfs_pkg::t_load load_word;
    wfs_pkg::t_step step;
    logic           accept;
    logic           slot_free;
    logic           unit_step;
    logic           out_load;
    logic           drop;
    logic [31:0]    n_offset;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_o_valid || m_axis_tready;
    assign unit_step = (r_state == ST_RUN) && (r_measure || slot_free);
    // output register takes a new result this cycle
    assign out_load  = (unit_step && !r_measure) || ((r_state == ST_REPORT) && slot_free);
    assign drop      = (r_offset >= r_limit);
    assign n_offset  = (r_offset == wfs_pkg::OFFSET_MAX) ? r_offset : r_offset + 32'd1;

    assign s_axis_tready = (r_state == ST_IDLE);

    wfs_decode u_decode (
        .i_kind     (s_axis_tuser),
        .i_value    (s_axis_tdata),
        .i_flexible (r_flexible),
        .o_load     (load_word)
    );

    wfs_byte_unit u_unit (
        .i_clk       (i_clk),
        .i_load      (accept),
        .i_load_word (load_word),
        .i_step      (unit_step),
        .o_step      (step)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flexible <= 1'b0;
            r_measure  <= 1'b0;
            r_limit    <= wfs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                wfs_pkg::CFG_FLEXIBLE: r_flexible <= i_cfg_data[0];
                wfs_pkg::CFG_MEASURE:  r_measure  <= i_cfg_data[0];
                wfs_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, running offset and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_offset  <= 32'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !out_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (load_word.enc != wfs_pkg::ENC_NONE) begin
                            r_state <= ST_RUN;
                        end else if (r_measure) begin
                            r_state <= ST_REPORT;
                        end
                    end
                end
                ST_RUN: begin
                    if (unit_step) begin
                        r_offset <= n_offset;
                        if (!r_measure) begin
                            r_o_valid      <= 1'b1;
                            r_o_byte       <= drop ? 8'd0 : step.data;
                            r_o_byte_valid <= ~drop;
                            r_o_ovf        <= drop;
                            r_o_offset     <= r_offset;
                            r_o_last       <= step.last;
                        end
                        if (step.last) begin
                            r_state <= r_measure ? ST_REPORT : ST_IDLE;
                        end
                    end
                end
                ST_REPORT: begin
                    if (slot_free) begin
                        r_o_valid      <= 1'b1;
                        r_o_byte       <= 8'd0;
                        r_o_byte_valid <= 1'b0;
                        r_o_ovf        <= 1'b0;
                        r_o_offset     <= r_offset;
                        r_o_last       <= 1'b1;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_offset, r_o_byte};
    assign m_axis_tuser  = {r_o_ovf, r_o_byte_valid};
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

>>> tb/sv/wire_field_serializer_tb.sv
// Self-checking testbench for the wire field serializer: encoding, offsets, limits, measure mode.
`default_nettype none

module wire_field_serializer_tb;

    localparam logic [3:0] KIND_UNUSED = 4'd15;  // decodes to no bytes
    localparam int QUIET_CYCLES = 24;            // longest field plus output register slack
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASE_ITEMS = 31;

    // One expected output transfer
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic [31:0] byte_offset;
        logic        overflow;
        logic        last;
    } t_wire_byte;

    // Mirror of the serializer state, the bytes each field should produce and their check
    class wire_byte_checker;
        bit          flexible = 1'b0;
        bit          measure = 1'b0;
        logic [31:0] limit = wfs_pkg::LIMIT_RESET;
        logic [31:0] offset = '0;
        logic [7:0]  field_bytes[10];
        int          field_len;
        t_wire_byte  expected_bytes[$];
        int          errors = 0;

        function void configure(logic [1:0] addr, logic [31:0] data);
            case (addr)
                wfs_pkg::CFG_FLEXIBLE: flexible = data[0];
                wfs_pkg::CFG_MEASURE:  measure = data[0];
                wfs_pkg::CFG_LIMIT:    limit = data;
                default: ;
            endcase
        endfunction

        // Append one expected transfer at the tail of the queue
        function void queue_expected(t_wire_byte r);
            expected_bytes = {expected_bytes, r};
        endfunction

        function void put_be(logic [63:0] v, int nbytes);
            for (int i = nbytes - 1; i >= 0; i--) begin
                field_bytes[field_len] = v[8*i +: 8];
                field_len++;
            end
        endfunction

        // LEB128 order: low group first, continuation bit on all but the last
        function void put_uvar(logic [63:0] x);
            while (x >= 64'h80) begin
                field_bytes[field_len] = {1'b1, x[6:0]};
                field_len++;
                x = x >> 7;
            end
            field_bytes[field_len] = x[7:0];
            field_len++;
        endfunction

        function void put_svar(logic [63:0] v);
            put_uvar((v << 1) ^ {64{v[63]}});
        endfunction

        function void encode_field(logic [3:0] kind, logic [63:0] v);
            field_len = 0;
            case (kind)
                wfs_pkg::KIND_I8:      put_be(v, 1);
                wfs_pkg::KIND_I16:     put_be(v, 2);
                wfs_pkg::KIND_I32:     put_be(v, 4);
                wfs_pkg::KIND_I64:     put_be(v, 8);
                wfs_pkg::KIND_SVARINT: put_svar(v);
                wfs_pkg::KIND_UVARINT: put_uvar(v);
                wfs_pkg::KIND_BOOL:    put_be((v != 0) ? 64'd1 : 64'd0, 1);
                wfs_pkg::KIND_ARRAYLEN: begin
                    if (flexible) put_uvar(v + 64'd1);
                    else put_be(v, 4);
                end
                wfs_pkg::KIND_BYTESLEN: begin
                    // fixed mode writes an empty byte string as the null length
                    if (flexible) put_uvar(v + 64'd1);
                    else put_be((v == 0) ? 64'hFFFF_FFFF : v, 4);
                end
                wfs_pkg::KIND_STRLEN: begin
                    if (flexible) put_uvar(v + 64'd1);
                    else put_be(v, 2);
                end
                wfs_pkg::KIND_NULLSTR: begin
                    if (flexible) put_uvar(64'd0);
                    else put_be(64'hFFFF, 2);
                end
                wfs_pkg::KIND_NULLARR: begin
                    if (flexible) put_uvar(64'd0);
                    else put_be(64'hFFFF_FFFF, 4);
                end
                wfs_pkg::KIND_VARBYTESLEN: put_svar((v == 0) ? '1 : v);
                wfs_pkg::KIND_TAGGED: begin
                    if (flexible) put_uvar(64'd0);
                end
                wfs_pkg::KIND_RAW: put_be(v, 1);
                default: ;
            endcase
        endfunction

        function logic [31:0] bump(logic [31:0] off);
            return (off == wfs_pkg::OFFSET_MAX) ? off : off + 32'd1;
        endfunction

        // Called on every accepted input transfer
        function void note_field(logic [3:0] kind, logic [63:0] v);
            t_wire_byte r;
            bit drop;
            encode_field(kind, v);
            if (measure) begin
                for (int i = 0; i < field_len; i++) offset = bump(offset);
                r = '{data_byte: 8'd0, byte_valid: 1'b0, byte_offset: offset,
                      overflow: 1'b0, last: 1'b1};
                queue_expected(r);
                return;
            end
            for (int i = 0; i < field_len; i++) begin
                drop = (offset >= limit);
                r = '{data_byte: drop ? 8'd0 : field_bytes[i], byte_valid: !drop,
                      byte_offset: offset, overflow: drop, last: (i == field_len - 1)};
                queue_expected(r);
                offset = bump(offset);
            end
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Called on every accepted output transfer
        function void check_byte(logic [7:0] data_byte, logic byte_valid,
                                 logic [31:0] byte_offset, logic overflow, logic last);
            t_wire_byte e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected output transfer: data 0x%0h offset %0d",
                       data_byte, byte_offset);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            compare_field("data_byte", e.data_byte, data_byte);
            compare_field("byte_valid", e.byte_valid, byte_valid);
            compare_field("byte_offset", e.byte_offset, byte_offset);
            compare_field("overflow", e.overflow, overflow);
            compare_field("last", e.last, last);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    wire logic        m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    wire logic [39:0] m_axis_tdata;
    wire logic [1:0]  m_axis_tuser;
    wire logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;

    wire_byte_checker checker_h = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_requests = 0;
    int rx_hold_served = 0;
    int rx_hold_left = 0;
    int cycle_count = 0;

    wire_field_serializer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus long holds on request
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_served != rx_hold_requests) begin
            rx_hold_served++;
            rx_hold_left = RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Transfer monitor: inputs are noted before outputs of the same edge are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                checker_h.note_field(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                checker_h.check_byte(m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[39:8],
                                     m_axis_tuser[1], m_axis_tlast);
        end
    end

    // Offer one field and wait for its transfer; tvalid stays high on return
    task automatic send_field(input logic [3:0] kind, input logic [63:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering, let every expected byte arrive, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (checker_h.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges; block must be idle
    task automatic set_config(input bit flex, input bit meas, input logic [31:0] limit);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= wfs_pkg::CFG_FLEXIBLE;
        i_cfg_data <= {31'd0, flex};
        checker_h.configure(wfs_pkg::CFG_FLEXIBLE, {31'd0, flex});
        @(posedge i_clk);
        i_cfg_addr <= wfs_pkg::CFG_MEASURE;
        i_cfg_data <= {31'd0, meas};
        checker_h.configure(wfs_pkg::CFG_MEASURE, {31'd0, meas});
        @(posedge i_clk);
        i_cfg_addr <= wfs_pkg::CFG_LIMIT;
        i_cfg_data <= limit;
        checker_h.configure(wfs_pkg::CFG_LIMIT, limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mix of full-width, short, negative and extreme values
    function automatic logic [63:0] random_value();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return wide;
            1: return 64'($urandom_range(0, 300));
            2: return wide >> $urandom_range(0, 63);
            3: return -(wide >> $urandom_range(0, 63));
            4: begin
                case ($urandom_range(0, 3))
                    0: return 64'd0;
                    1: return '1;
                    2: return 64'h8000_0000_0000_0000;
                    default: return 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            default: return 64'($urandom_range(0, 20));
        endcase
    endfunction

    task automatic run_phase(input bit flex, input bit meas, input logic [31:0] limit,
                             input int tx_pct, input int rx_pct,
                             input bit hold_rx, input bit pause_midway);
        wait_drained();
        set_config(flex, meas, limit);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold_rx) rx_hold_requests++;
        for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
            if (pause_midway && i == RANDOM_PHASE_ITEMS / 2) wait_drained();
            send_field(4'($urandom_range(0, 15)), random_value());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fixed headers, every kind and the field extremes
        tx_idle_pct = 15;
        rx_idle_pct = 84;
        set_config(1'b0, 1'b0, wfs_pkg::LIMIT_RESET);
        send_field(wfs_pkg::KIND_I8, 64'h80);
        send_field(wfs_pkg::KIND_I16, 64'hFFFF_FFFF_FFFF_8000);
        send_field(wfs_pkg::KIND_I32, 64'h1234_5678_DEAD_BEEF);
        send_field(wfs_pkg::KIND_I64, 64'h8000_0000_0000_0000);
        send_field(wfs_pkg::KIND_SVARINT, 64'h8000_0000_0000_0000);
        send_field(wfs_pkg::KIND_UVARINT, '1);
        send_field(wfs_pkg::KIND_BOOL, 64'd0);
        send_field(wfs_pkg::KIND_BOOL, 64'h8000_0000_0000_0000);
        send_field(wfs_pkg::KIND_ARRAYLEN, '1);
        send_field(wfs_pkg::KIND_BYTESLEN, 64'd0);
        send_field(wfs_pkg::KIND_STRLEN, 64'h7FFF);
        send_field(wfs_pkg::KIND_NULLSTR, 64'd0);
        send_field(wfs_pkg::KIND_NULLARR, 64'd0);
        send_field(wfs_pkg::KIND_VARBYTESLEN, 64'd0);
        send_field(wfs_pkg::KIND_TAGGED, 64'd0);
        send_field(wfs_pkg::KIND_RAW, 64'hFF);
        send_field(KIND_UNUSED, 64'd0);
        send_field(wfs_pkg::KIND_I64, 64'h7FFF_FFFF_FFFF_FFFF);

        // Directed: compact varint headers, null by minus one, empty tagged field
        wait_drained();
        set_config(1'b1, 1'b0, wfs_pkg::LIMIT_RESET);
        send_field(wfs_pkg::KIND_ARRAYLEN, '1);
        send_field(wfs_pkg::KIND_BYTESLEN, 64'd0);
        send_field(wfs_pkg::KIND_STRLEN, 64'h7FFF_FFFF_FFFF_FFFF);
        send_field(wfs_pkg::KIND_NULLSTR, 64'd0);
        send_field(wfs_pkg::KIND_NULLARR, 64'd0);
        send_field(wfs_pkg::KIND_TAGGED, 64'd0);
        send_field(wfs_pkg::KIND_UVARINT, 64'h7F);

        // Random phases across header modes, measure mode and buffer limits
        run_phase(1'b0, 1'b0, wfs_pkg::LIMIT_RESET, 15, 84, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, checker_h.offset + 32'($urandom_range(5, 40)), 15, 84, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, 32'd0, 84, 15, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 32'd0, 84, 15, 1'b0, 1'b1);
        run_phase(1'b1, 1'b1, wfs_pkg::LIMIT_RESET, 0, 0, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, checker_h.offset + 32'($urandom_range(0, 60)), 0, 0, 1'b1, 1'b0);

        wait_drained();
        if (checker_h.expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", checker_h.expected_bytes.size());
            checker_h.errors++;
        end
        if (checker_h.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
